>>> rtl/assert_macros.svh
// assertion macros used by barycentric_pixel_shader_top
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> rtl/bps_pkg.sv
// widths and types for the barycentric pixel shader pipeline
// no dependencies
package bps_pkg;
   localparam int COORD_BITS     = 12;
   localparam int DIFF_W         = COORD_BITS + 1;
   localparam int PROD_W         = 2 * DIFF_W;
   localparam int CROSS_W        = PROD_W + 1;
   localparam int NUM_W          = CROSS_W + 1;
   localparam int WGT_W          = 2 * COORD_BITS + 1;
   localparam int CHAN_W         = 8;
   localparam int COLOR_W        = 3 * CHAN_W;
   localparam int NCHAN          = 3;
   localparam int SUM_W          = WGT_W + CHAN_W + 2;
   localparam int DIV_BITS       = CHAN_W;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = DIV_BITS / BITS_PER_STAGE;
   localparam int DIV_LAST       = DIV_STAGES - 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [CROSS_W-1:0]    cross_type;
   typedef logic signed [NUM_W-1:0]      num_type;
   typedef logic [WGT_W-1:0]             wgt_type;
   typedef logic [SUM_W-1:0]             sum_type;
   typedef logic [CHAN_W-1:0]            chan_type;
   typedef logic [COLOR_W-1:0]           color_type;
endpackage

>>> rtl/barycentric_pixel_shader_top.sv
// barycentric pixel shader: coverage test and colour interpolation, fully pipelined
// depends on bps_pkg and assert_macros.svh
//
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_stall  three vertices, three colours, pixel
//  rsp_     out        rsp_valid / rsp_stall  covered, out_x, out_y, red, green, blue
//
//  one transaction enters per clock while req_stall is low; 6 arithmetic stages
//  plus 4 divider stages of 2 quotient bits each
//  reset is synchronous and clears only the stage valid bits
//  the whole pipe holds while rsp_valid is high and rsp_stall is high,
//  so req_stall follows that condition and nothing is lost or repeated
`include "assert_macros.svh"

module barycentric_pixel_shader_top import bps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  coord_type        req_vertex0_x,
   input  coord_type        req_vertex0_y,
   input  coord_type        req_vertex1_x,
   input  coord_type        req_vertex1_y,
   input  coord_type        req_vertex2_x,
   input  coord_type        req_vertex2_y,
   input  color_type        req_vertex0_color,
   input  color_type        req_vertex1_color,
   input  color_type        req_vertex2_color,
   input  coord_type        req_pixel_x,
   input  coord_type        req_pixel_y,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_covered,
   output coord_type        rsp_out_x,
   output coord_type        rsp_out_y,
   output chan_type         rsp_red,
   output chan_type         rsp_green,
   output chan_type         rsp_blue
);

   // global advance: the last stage is free or being drained
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- stage 1: edge vectors
   logic      v1_ff;
   diff_type  ux_ff, uy_ff, vx_ff, vy_ff, pox_ff, poy_ff;
   color_type c1_ff [NCHAN];
   coord_type px1_ff, py1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         ux_ff  <= DIFF_W'(req_vertex1_x) - DIFF_W'(req_vertex0_x);
         uy_ff  <= DIFF_W'(req_vertex1_y) - DIFF_W'(req_vertex0_y);
         vx_ff  <= DIFF_W'(req_vertex2_x) - DIFF_W'(req_vertex0_x);
         vy_ff  <= DIFF_W'(req_vertex2_y) - DIFF_W'(req_vertex0_y);
         pox_ff <= DIFF_W'(req_vertex0_x) - DIFF_W'(req_pixel_x);
         poy_ff <= DIFF_W'(req_vertex0_y) - DIFF_W'(req_pixel_y);
         c1_ff[0] <= req_vertex0_color;
         c1_ff[1] <= req_vertex1_color;
         c1_ff[2] <= req_vertex2_color;
         px1_ff <= req_pixel_x;
         py1_ff <= req_pixel_y;
      end
   end

   // ---------------- stage 2: the six cross products
   logic      v2_ff;
   prod_type  p_vxpy_ff, p_pxvy_ff, p_pxuy_ff, p_uxpy_ff, p_uxvy_ff, p_vxuy_ff;
   color_type c2_ff [NCHAN];
   coord_type px2_ff, py2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         p_vxpy_ff <= PROD_W'(vx_ff) * PROD_W'(poy_ff);
         p_pxvy_ff <= PROD_W'(pox_ff) * PROD_W'(vy_ff);
         p_pxuy_ff <= PROD_W'(pox_ff) * PROD_W'(uy_ff);
         p_uxpy_ff <= PROD_W'(ux_ff) * PROD_W'(poy_ff);
         p_uxvy_ff <= PROD_W'(ux_ff) * PROD_W'(vy_ff);
         p_vxuy_ff <= PROD_W'(vx_ff) * PROD_W'(uy_ff);
         c2_ff  <= c1_ff;
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
      end
   end

   // ---------------- stage 3: numerators n1, n2 and determinant
   logic      v3_ff;
   cross_type n1_ff, n2_ff, det_ff;
   color_type c3_ff [NCHAN];
   coord_type px3_ff, py3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         n1_ff  <= CROSS_W'(p_vxpy_ff) - CROSS_W'(p_pxvy_ff);
         n2_ff  <= CROSS_W'(p_pxuy_ff) - CROSS_W'(p_uxpy_ff);
         det_ff <= CROSS_W'(p_uxvy_ff) - CROSS_W'(p_vxuy_ff);
         c3_ff  <= c2_ff;
         px3_ff <= px2_ff;
         py3_ff <= py2_ff;
      end
   end

   // ---------------- stage 4: n0, winding fix and coverage
   num_type n0_s, n0_a, n1_a, n2_a, d_a;
   logic    cov_s;

   always_comb begin
      n0_s = NUM_W'(det_ff) - NUM_W'(n1_ff) - NUM_W'(n2_ff);
      if (det_ff < 0) begin
         d_a  = -NUM_W'(det_ff);
         n0_a = -n0_s;
         n1_a = -NUM_W'(n1_ff);
         n2_a = -NUM_W'(n2_ff);
      end else begin
         d_a  = NUM_W'(det_ff);
         n0_a = n0_s;
         n1_a = NUM_W'(n1_ff);
         n2_a = NUM_W'(n2_ff);
      end
      // zero numerator counts as inside (pixel on an edge)
      cov_s = (det_ff != '0) && (n0_a >= 0) && (n1_a >= 0) && (n2_a >= 0);
   end

   logic      v4_ff, cov4_ff;
   wgt_type   w4_ff [NCHAN];
   wgt_type   d4_ff;
   color_type c4_ff [NCHAN];
   coord_type px4_ff, py4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         cov4_ff  <= cov_s;
         // weights are bounded by the determinant when covered
         w4_ff[0] <= cov_s ? WGT_W'(n0_a) : '0;
         w4_ff[1] <= cov_s ? WGT_W'(n1_a) : '0;
         w4_ff[2] <= cov_s ? WGT_W'(n2_a) : '0;
         d4_ff    <= cov_s ? WGT_W'(d_a) : wgt_type'(1);
         c4_ff    <= c3_ff;
         px4_ff   <= px3_ff;
         py4_ff   <= py3_ff;
      end
   end

   // ---------------- stage 5: weight times channel, nine products
   logic      v5_ff, cov5_ff;
   sum_type   wc5_ff [NCHAN][NCHAN];   // [channel][vertex]
   wgt_type   d5_ff;
   coord_type px5_ff, py5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         for (int k = 0; k < NCHAN; k++) begin
            for (int j = 0; j < NCHAN; j++) begin
               // red sits in the top byte, so channel k reads byte NCHAN-1-k
               wc5_ff[k][j] <= SUM_W'(w4_ff[j]) *
                               SUM_W'(c4_ff[j][(NCHAN-1-k)*CHAN_W +: CHAN_W]);
            end
         end
         cov5_ff <= cov4_ff;
         d5_ff   <= d4_ff;
         px5_ff  <= px4_ff;
         py5_ff  <= py4_ff;
      end
   end

   // ---------------- stage 6: channel sums
   logic      v6_ff, cov6_ff;
   sum_type   s6_ff [NCHAN];
   wgt_type   d6_ff;
   coord_type px6_ff, py6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
      if (adv) begin
         for (int k = 0; k < NCHAN; k++) begin
            s6_ff[k] <= wc5_ff[k][0] + wc5_ff[k][1] + wc5_ff[k][2];
         end
         cov6_ff <= cov5_ff;
         d6_ff   <= d5_ff;
         px6_ff  <= px5_ff;
         py6_ff  <= py5_ff;
      end
   end

   // ---------------- stages 7..10: restoring divider, two quotient bits per stage
   // the quotient fits 8 bits since the weights sum to the determinant
   logic      dv_ff   [DIV_STAGES];
   logic      dcov_ff [DIV_STAGES];
   sum_type   rem_ff  [DIV_STAGES][NCHAN];
   chan_type  quo_ff  [DIV_STAGES][NCHAN];
   wgt_type   dd_ff   [DIV_STAGES];
   coord_type dx_ff   [DIV_STAGES];
   coord_type dy_ff   [DIV_STAGES];

   sum_type   rem_in  [DIV_STAGES][NCHAN];
   chan_type  quo_in  [DIV_STAGES][NCHAN];

   always_comb begin
      for (int st = 0; st < DIV_STAGES; st++) begin
         for (int k = 0; k < NCHAN; k++) begin
            sum_type  r;
            chan_type q;
            sum_type  dsh;
            r = (st == 0) ? s6_ff[k] : rem_ff[(st == 0) ? 0 : st - 1][k];
            q = (st == 0) ? '0 : quo_ff[(st == 0) ? 0 : st - 1][k];
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
               dsh = SUM_W'((st == 0) ? d6_ff : dd_ff[(st == 0) ? 0 : st - 1])
                     << (DIV_BITS - 1 - (st * BITS_PER_STAGE + j));
               q = q << 1;
               if (r >= dsh) begin
                  r    = r - dsh;
                  q[0] = 1'b1;
               end
            end
            rem_in[st][k] = r;
            quo_in[st][k] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int st = 0; st < DIV_STAGES; st++) begin
            dv_ff[st] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= v6_ff;
         for (int st = 1; st < DIV_STAGES; st++) begin
            dv_ff[st] <= dv_ff[st-1];
         end
      end
      if (adv) begin
         for (int st = 0; st < DIV_STAGES; st++) begin
            rem_ff[st] <= rem_in[st];
            quo_ff[st] <= quo_in[st];
         end
         dcov_ff[0] <= cov6_ff;
         dd_ff[0]   <= d6_ff;
         dx_ff[0]   <= px6_ff;
         dy_ff[0]   <= py6_ff;
         for (int st = 1; st < DIV_STAGES; st++) begin
            dcov_ff[st] <= dcov_ff[st-1];
            dd_ff[st]   <= dd_ff[st-1];
            dx_ff[st]   <= dx_ff[st-1];
            dy_ff[st]   <= dy_ff[st-1];
         end
      end
   end

   // ---------------- result drive from the last divider stage
   assign rsp_valid   = dv_ff[DIV_LAST];
   assign rsp_covered = dcov_ff[DIV_LAST];
   assign rsp_out_x   = dx_ff[DIV_LAST];
   assign rsp_out_y   = dy_ff[DIV_LAST];
   // uncovered pixels carry zero sums, force the colour to zero anyway
   assign rsp_red     = dcov_ff[DIV_LAST] ? quo_ff[DIV_LAST][0] : '0;
   assign rsp_green   = dcov_ff[DIV_LAST] ? quo_ff[DIV_LAST][1] : '0;
   assign rsp_blue    = dcov_ff[DIV_LAST] ? quo_ff[DIV_LAST][2] : '0;

   // ---------------- checks
   `ASSERT_IMPLY(a_uncov_black, clock, reset, rsp_valid && !rsp_covered,
      rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)
   `ASSERT_IMPLY(a_div_nonzero, clock, reset, v6_ff, d6_ff != '0)
   `ASSERT_NEVER(a_rem_bound, clock, reset,
      rsp_valid && rsp_covered && (rem_ff[DIV_LAST][0] >= SUM_W'(dd_ff[DIV_LAST])))
endmodule

>>> tb/testbench.sv
// self-checking testbench for barycentric_pixel_shader_top: coverage and colour checks
// depends on bps_pkg and the rtl of barycentric_pixel_shader_top
`timescale 1ns / 1ps

module testbench;
   import bps_pkg::*;

   // one pixel test against one triangle
   typedef struct {
      coord_type x0, y0, x1, y1, x2, y2;
      color_type c0, c1, c2;
      coord_type px, py;
   } pixel_job_type;

   // expected shaded pixel
   typedef struct {
      logic      covered;
      coord_type out_x, out_y;
      chan_type  red, green, blue;
   } shaded_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid = 1'b0;
   logic      req_stall;
   logic      req_stall_q = 1'b1;
   coord_type req_vertex0_x = '0, req_vertex0_y = '0;
   coord_type req_vertex1_x = '0, req_vertex1_y = '0;
   coord_type req_vertex2_x = '0, req_vertex2_y = '0;
   color_type req_vertex0_color = '0, req_vertex1_color = '0, req_vertex2_color = '0;
   coord_type req_pixel_x = '0, req_pixel_y = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_covered;
   coord_type rsp_out_x, rsp_out_y;
   chan_type  rsp_red, rsp_green, rsp_blue;

   pixel_job_type    pending_jobs[$];
   shaded_pixel_type expected_pixels[$];
   int               error_count = 0;
   bit               stimulus_done = 1'b0;
   bit               drain_hold = 1'b0;
   int               send_gap = 0;
   int               stall_left = 0;

   barycentric_pixel_shader_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vertex0_x(req_vertex0_x), .req_vertex0_y(req_vertex0_y),
      .req_vertex1_x(req_vertex1_x), .req_vertex1_y(req_vertex1_y),
      .req_vertex2_x(req_vertex2_x), .req_vertex2_y(req_vertex2_y),
      .req_vertex0_color(req_vertex0_color), .req_vertex1_color(req_vertex1_color),
      .req_vertex2_color(req_vertex2_color),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_covered(rsp_covered), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // exact integer shading of one pixel, both windings treated alike
   function automatic shaded_pixel_type shade_pixel(pixel_job_type j);
      shaded_pixel_type r;
      longint ux, uy, vx, vy, ox, oy, n0, n1, n2, det, s;
      ux = longint'(j.x1) - longint'(j.x0);
      uy = longint'(j.y1) - longint'(j.y0);
      vx = longint'(j.x2) - longint'(j.x0);
      vy = longint'(j.y2) - longint'(j.y0);
      ox = longint'(j.x0) - longint'(j.px);
      oy = longint'(j.y0) - longint'(j.py);
      n1 = vx * oy - ox * vy;
      n2 = ox * uy - ux * oy;
      det = ux * vy - vx * uy;
      n0 = det - n1 - n2;
      r.covered = 1'b0;
      r.out_x = j.px;
      r.out_y = j.py;
      r.red = '0;
      r.green = '0;
      r.blue = '0;
      if (det != 0) begin
         if (det < 0) begin
            det = -det; n0 = -n0; n1 = -n1; n2 = -n2;
         end
         if (n0 >= 0 && n1 >= 0 && n2 >= 0) begin
            r.covered = 1'b1;
            s = n0 * j.c0[23:16] + n1 * j.c1[23:16] + n2 * j.c2[23:16];
            r.red = chan_type'(s / det);
            s = n0 * j.c0[15:8] + n1 * j.c1[15:8] + n2 * j.c2[15:8];
            r.green = chan_type'(s / det);
            s = n0 * j.c0[7:0] + n1 * j.c1[7:0] + n2 * j.c2[7:0];
            r.blue = chan_type'(s / det);
         end
      end
      return r;
   endfunction

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   // small triangle around a random point, pixel near it, so coverage is common
   function automatic pixel_job_type near_triangle(int span);
      pixel_job_type j;
      int cx, cy;
      cx = $urandom_range(4095 - 2 * span, 0) - 2048 + span;
      cy = $urandom_range(4095 - 2 * span, 0) - 2048 + span;
      j.x0 = coord_type'(cx + $urandom_range(2 * span, 0) - span);
      j.y0 = coord_type'(cy + $urandom_range(2 * span, 0) - span);
      j.x1 = coord_type'(cx + $urandom_range(2 * span, 0) - span);
      j.y1 = coord_type'(cy + $urandom_range(2 * span, 0) - span);
      j.x2 = coord_type'(cx + $urandom_range(2 * span, 0) - span);
      j.y2 = coord_type'(cy + $urandom_range(2 * span, 0) - span);
      j.px = coord_type'(cx + $urandom_range(span, 0) - span / 2);
      j.py = coord_type'(cy + $urandom_range(span, 0) - span / 2);
      j.c0 = color_type'($urandom);
      j.c1 = color_type'($urandom);
      j.c2 = color_type'($urandom);
      return j;
   endfunction

   function automatic pixel_job_type make_job(int x0, int y0, int x1, int y1, int x2, int y2,
                                              int c0, int c1, int c2, int px, int py);
      pixel_job_type j;
      j.x0 = coord_type'(x0); j.y0 = coord_type'(y0);
      j.x1 = coord_type'(x1); j.y1 = coord_type'(y1);
      j.x2 = coord_type'(x2); j.y2 = coord_type'(y2);
      j.c0 = color_type'(c0); j.c1 = color_type'(c1); j.c2 = color_type'(c2);
      j.px = coord_type'(px); j.py = coord_type'(py);
      return j;
   endfunction

   // mostly short gaps, a few long ones, often none
   function automatic int random_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // stimulus: directed corner cases first, then random
   initial begin
      pixel_job_type j;
      // full-range triangle, pixel at the origin, colours at extremes
      pending_jobs.push_back(make_job(-2048, -2048, 2047, -2048, -2048, 2047,
                                      'hFFFFFF, 'h000000, 'hFFFFFF, 0, 0));
      // opposite winding of the same triangle
      pending_jobs.push_back(make_job(-2048, -2048, -2048, 2047, 2047, -2048,
                                      'hFF0000, 'h00FF00, 'h0000FF, 0, 0));
      // pixel on each vertex
      pending_jobs.push_back(make_job(0, 0, 100, 0, 0, 100, 'h123456, 'hABCDEF, 'h00FF80, 0, 0));
      pending_jobs.push_back(make_job(0, 0, 100, 0, 0, 100, 'h123456, 'hABCDEF, 'h00FF80, 100, 0));
      pending_jobs.push_back(make_job(0, 0, 100, 0, 0, 100, 'h123456, 'hABCDEF, 'h00FF80, 0, 100));
      // pixel on edges
      pending_jobs.push_back(make_job(0, 0, 100, 0, 0, 100, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 50, 50));
      pending_jobs.push_back(make_job(0, 0, 100, 0, 0, 100, 'h808080, 'h7F7F7F, 'h010203, 50, 0));
      // pixel just outside
      pending_jobs.push_back(make_job(0, 0, 100, 0, 0, 100, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 51, 50));
      pending_jobs.push_back(make_job(0, 0, 100, 0, 0, 100, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, -1, 0));
      // degenerate: collinear and coincident vertices
      pending_jobs.push_back(make_job(0, 0, 10, 10, 20, 20, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 10, 10));
      pending_jobs.push_back(make_job(5, 5, 5, 5, 5, 5, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 5, 5));
      // extreme pixel positions and wrapping extremes
      pending_jobs.push_back(make_job(2047, 2047, -2048, 2047, 2047, -2048,
                                      'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 2047, 2047));
      pending_jobs.push_back(make_job(2047, 2047, -2048, 2047, 2047, -2048,
                                      'h000000, 'h000000, 'h000000, -2048, -2048));
      pending_jobs.push_back(make_job(-2048, 2047, 2047, -2048, 2047, 2047,
                                      'hFFFFFF, 'h000000, 'h000000, 2047, 2047));
      // tiny triangles with truncating division
      pending_jobs.push_back(make_job(0, 0, 3, 0, 0, 3, 'hFF00FF, 'h00FF00, 'h7F7F7F, 1, 1));
      pending_jobs.push_back(make_job(0, 0, 0, 3, 3, 0, 'h010101, 'hFEFEFE, 'h020202, 1, 0));
      // all-ones colours at full extent
      pending_jobs.push_back(make_job(-2048, -2048, 2047, 0, 0, 2047,
                                      'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 100, 200));
      for (int i = 0; i < 1950; i++) begin
         case ($urandom_range(9, 0))
            0, 1, 2: j = near_triangle(8);
            3, 4, 5: j = near_triangle(200);
            6: j = near_triangle(1000);
            7: begin
               // pixel on a vertex of a random triangle
               j = near_triangle(50);
               case ($urandom_range(2, 0))
                  0: begin j.px = j.x0; j.py = j.y0; end
                  1: begin j.px = j.x1; j.py = j.y1; end
                  default: begin j.px = j.x2; j.py = j.y2; end
               endcase
            end
            default: begin
               j = near_triangle(4);
               j.x0 = any_coord(); j.y0 = any_coord();
               j.x1 = any_coord(); j.y1 = any_coord();
               j.x2 = any_coord(); j.y2 = any_coord();
               j.px = any_coord(); j.py = any_coord();
            end
         endcase
         pending_jobs.push_back(j);
      end
   end

   // driver: one transaction per accepted handshake, changes at falling edge
   always @(negedge clock) begin
      pixel_job_type j;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall_q) begin
            // the previous transaction was taken at the last rising edge
            void'(pending_jobs.pop_front());
            if (pending_jobs.size() == 0) stimulus_done = 1'b1;
            send_gap = random_gap();
            if (pending_jobs.size() == 1000 || pending_jobs.size() == 400) drain_hold = 1'b1;
         end
         if (drain_hold && expected_pixels.size() == 0) drain_hold = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!drain_hold && pending_jobs.size() > 0) begin
            j = pending_jobs[0];
            req_valid <= 1'b1;
            req_vertex0_x <= j.x0; req_vertex0_y <= j.y0;
            req_vertex1_x <= j.x1; req_vertex1_y <= j.y1;
            req_vertex2_x <= j.x2; req_vertex2_y <= j.y2;
            req_vertex0_color <= j.c0;
            req_vertex1_color <= j.c1;
            req_vertex2_color <= j.c2;
            req_pixel_x <= j.px; req_pixel_y <= j.py;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // acceptance seen at the rising edge, predicted results queued there
   always @(posedge clock) begin
      req_stall_q <= reset || !req_valid || req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_pixels.push_back(shade_pixel(pending_jobs[0]));
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      shaded_pixel_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result x", rsp_out_x, 0);
         end else begin
            e = expected_pixels.pop_front();
            if (rsp_covered !== e.covered) report_mismatch("covered", rsp_covered, e.covered);
            if (rsp_out_x !== e.out_x) report_mismatch("out_x", rsp_out_x, e.out_x);
            if (rsp_out_y !== e.out_y) report_mismatch("out_y", rsp_out_y, e.out_y);
            if (rsp_red !== e.red) report_mismatch("red", rsp_red, e.red);
            if (rsp_green !== e.green) report_mismatch("green", rsp_green, e.green);
            if (rsp_blue !== e.blue) report_mismatch("blue", rsp_blue, e.blue);
         end
      end
   end

   // receiver back-pressure, random lengths with quiet stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(99, 0) < 20) stall_left = random_gap();
      end
   end

   // reset, then wait for the drain and the pipeline tail
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (stimulus_done && expected_pixels.size() == 0);
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4ms;
      $display("status: fail");
      $finish;
   end
endmodule

>>> barycentric_pixel_shader_top.f
+incdir+rtl
rtl/bps_pkg.sv
rtl/barycentric_pixel_shader_top.sv
tb/testbench.sv
